// ===== rtl/pulse_window_finder_core_macros.svh =====
// Assertion macros shared by the pulse window finder RTL.
`ifndef PULSE_WINDOW_FINDER_CORE_MACROS_SVH
`define PULSE_WINDOW_FINDER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PWF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PWF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pwf_pkg.sv =====
// Constants, register indexes and the stop-rule function of the pulse window finder.
package pwf_pkg;

   localparam int MAX_SAMPLES = 4096;
   localparam int SAMPLE_W    = 14;
   localparam int VALUE_W     = SAMPLE_W + 1;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int COUNT_W     = ADDR_W + 1;
   localparam int FRAC_W      = 8;
   localparam int THR_W       = VALUE_W + FRAC_W + 1;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 56;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_PEDESTAL    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_RULE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_RULE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRACTION_Q8 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_REACH  = 3'd4;

   // Stop rule codes
   localparam logic [1:0] RULE_SLOPE     = 2'd0;
   localparam logic [1:0] RULE_PEDESTAL  = 2'd1;
   localparam logic [1:0] RULE_FRACTION  = 2'd2;

   // Below any value a sample can store
   localparam logic signed [VALUE_W-1:0] BEST_RESET = {1'b1, {(VALUE_W-1){1'b0}}};

   // True while the scan may step past this sample. For the slope rule the
   // neighbour is the next sample away from the peak in either direction.
   function automatic logic rule_holds(input logic [1:0] rule,
                                       input logic signed [VALUE_W-1:0] here,
                                       input logic signed [VALUE_W-1:0] beyond,
                                       input logic signed [THR_W-1:0] thr);
      logic signed [THR_W-1:0] scaled;
      logic                    ok;
      scaled = $signed({here[VALUE_W-1], here, {FRAC_W{1'b0}}});
      case (rule)
         RULE_SLOPE:    ok = here > beyond;
         RULE_PEDESTAL: ok = here > $signed({VALUE_W{1'b0}});
         RULE_FRACTION: ok = scaled > thr;
         default:       ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

// ===== rtl/pulse_window_finder_core.sv =====
// Pulse window finder: loads a waveform, finds its peak and scans out the pulse window.
//
// Raw samples stream in one per cycle (tlast marks the final one) and are
// stored as pedestal minus raw in a 4096 x 15 sample memory while the first
// maximum is tracked. After the final sample the block stops taking samples
// and scans backward, then forward from the peak through the memory's single
// read port, one sample per cycle. Each scan stops where its stop rule fails
// or at the window edge set by the scan reach and sample count (a zero reach
// counts as one). Once the result register is free the result is written
// to it, which frees the block to load the next waveform while the result
// waits to be taken. Configuration writes are taken in every cycle and
// should be made between waveforms.
`include "pulse_window_finder_core_macros.svh"

module pulse_window_finder_core
   import pwf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Sample stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [13:0] raw_sample
   input  logic                  req_tlast,   // last_sample
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [11:0] peak_index, [26:12] peak_height,
                                              // [38:27] start_index, [50:39] end_index
   // Configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SETUP,
      ST_BK_INIT,
      ST_BK_PRIME,
      ST_BK_RUN,
      ST_FW_INIT,
      ST_FW_PRIME,
      ST_FW_RUN,
      ST_EMIT
   } state_type;

   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(MAX_SAMPLES);

   // Configuration registers
   logic [SAMPLE_W-1:0] pedestal_ff;
   logic [1:0]          start_rule_ff;
   logic [1:0]          end_rule_ff;
   logic [FRAC_W-1:0]   fraction_ff;
   logic [ADDR_W-1:0]   reach_ff;

   // Control and scan state
   state_type                   state_ff, state_in;
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic signed [VALUE_W-1:0]   best_val_ff, best_val_in;
   logic [ADDR_W-1:0]           best_pos_ff, best_pos_in;
   logic [ADDR_W-1:0]           peak_pos_ff, peak_pos_in;
   logic signed [VALUE_W-1:0]   peak_val_ff, peak_val_in;
   logic [ADDR_W-1:0]           lo_ff, lo_in;
   logic [COUNT_W-1:0]          hi_ff, hi_in;
   logic signed [THR_W-1:0]     thr_ff, thr_in;
   logic [ADDR_W-1:0]           s_ff, s_in;
   logic [ADDR_W-1:0]           e_ff, e_in;
   logic signed [VALUE_W-1:0]   cur_ff, cur_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]       rsp_data_ff, rsp_data_in;

   // Sample memory
   logic signed [VALUE_W-1:0]   mem [MAX_SAMPLES];
   logic signed [VALUE_W-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]           rd_addr;
   logic                        wr_en;
   logic signed [VALUE_W-1:0]   wr_value;

   // Helpers
   logic                        req_xfer;
   logic [ADDR_W-1:0]           reach_eff;
   logic [COUNT_W-1:0]          hi_sum;
   logic [COUNT_W-1:0]          peak_ext;
   logic                        go;
   logic [1:0]                  rule_sel;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign wr_value  = $signed({1'b0, pedestal_ff}) - $signed({1'b0, req_tdata[SAMPLE_W-1:0]});
   assign wr_en     = req_xfer && (count_ff != COUNT_FULL);
   assign reach_eff = (reach_ff == '0) ? ADDR_W'(1) : reach_ff;
   assign hi_sum    = {1'b0, best_pos_ff} + {1'b0, reach_eff};
   assign peak_ext  = {1'b0, peak_pos_ff};
   assign rule_sel  = (state_ff == ST_BK_RUN) ? start_rule_ff : end_rule_ff;
   assign go        = rule_holds(rule_sel, cur_ff, rd_data_ff, thr_ff);

   // Store samples and read one entry a cycle for the scans
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[ADDR_W-1:0]] <= wr_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pedestal_ff   <= '0;
         start_rule_ff <= RULE_FRACTION;
         end_rule_ff   <= RULE_FRACTION;
         fraction_ff   <= FRAC_W'(26);
         reach_ff      <= ADDR_W'(100);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PEDESTAL:    pedestal_ff   <= csr_wdata[SAMPLE_W-1:0];
            CSR_START_RULE:  start_rule_ff <= csr_wdata[1:0];
            CSR_END_RULE:    end_rule_ff   <= csr_wdata[1:0];
            CSR_FRACTION_Q8: fraction_ff   <= csr_wdata[FRAC_W-1:0];
            CSR_SCAN_REACH:  reach_ff      <= csr_wdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: load, set up the window, scan back, scan forward, emit
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      best_val_in  = best_val_ff;
      best_pos_in  = best_pos_ff;
      peak_pos_in  = peak_pos_ff;
      peak_val_in  = peak_val_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      thr_in       = thr_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = s_ff;

      // Drop the result once it has been taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (wr_en) begin
               count_in = count_ff + COUNT_W'(1);
               if (wr_value > best_val_ff) begin
                  best_val_in = wr_value;
                  best_pos_in = count_ff[ADDR_W-1:0];
               end
            end
            if (req_xfer && req_tlast) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // Capture peak and window bounds, then clear the tracker
            peak_pos_in = best_pos_ff;
            peak_val_in = best_val_ff;
            lo_in       = (best_pos_ff > reach_eff) ? best_pos_ff - reach_eff : '0;
            hi_in       = (hi_sum < count_ff) ? hi_sum : count_ff;
            thr_in      = THR_W'(best_val_ff) * THR_W'($signed({1'b0, fraction_ff}));
            count_in    = '0;
            best_val_in = BEST_RESET;
            best_pos_in = '0;
            state_in    = ST_BK_INIT;
         end
         ST_BK_INIT: begin
            if (peak_pos_ff <= lo_ff) begin
               s_in     = peak_pos_ff;
               state_in = ST_FW_INIT;
            end else begin
               s_in    = peak_pos_ff - ADDR_W'(1);
               rd_addr = peak_pos_ff - ADDR_W'(1);
               if ((peak_pos_ff - ADDR_W'(1)) <= lo_ff) begin
                  state_in = ST_FW_INIT;
               end else begin
                  state_in = ST_BK_PRIME;
               end
            end
         end
         ST_BK_PRIME: begin
            cur_in   = rd_data_ff;
            rd_addr  = s_ff - ADDR_W'(1);
            state_in = ST_BK_RUN;
         end
         ST_BK_RUN: begin
            // rd_data_ff holds the sample below s
            rd_addr = s_ff - ADDR_W'(2);
            if (go) begin
               s_in   = s_ff - ADDR_W'(1);
               cur_in = rd_data_ff;
               if ((s_ff - ADDR_W'(1)) <= lo_ff) begin
                  state_in = ST_FW_INIT;
               end
            end else begin
               state_in = ST_FW_INIT;
            end
         end
         ST_FW_INIT: begin
            if ((peak_ext + COUNT_W'(1)) >= hi_ff) begin
               e_in     = peak_pos_ff;
               state_in = ST_EMIT;
            end else begin
               e_in    = peak_pos_ff + ADDR_W'(1);
               rd_addr = peak_pos_ff + ADDR_W'(1);
               if ((peak_ext + COUNT_W'(2)) >= hi_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_FW_PRIME;
               end
            end
         end
         ST_FW_PRIME: begin
            cur_in   = rd_data_ff;
            rd_addr  = e_ff + ADDR_W'(1);
            state_in = ST_FW_RUN;
         end
         ST_FW_RUN: begin
            // rd_data_ff holds the sample above e
            rd_addr = e_ff + ADDR_W'(2);
            if (go) begin
               e_in   = e_ff + ADDR_W'(1);
               cur_in = rd_data_ff;
               if (({1'b0, e_ff} + COUNT_W'(2)) >= hi_ff) begin
                  state_in = ST_EMIT;
               end
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, e_ff, s_ff, peak_val_ff, peak_pos_ff};
               state_in     = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         best_val_ff  <= BEST_RESET;
         best_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         best_val_ff  <= best_val_in;
         best_pos_ff  <= best_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      peak_pos_ff <= peak_pos_in;
      peak_val_ff <= peak_val_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      thr_ff      <= thr_in;
      s_ff        <= s_in;
      e_ff        <= e_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   `PWF_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= COUNT_FULL,
                   "sample count past memory depth")
   `PWF_ASSERT_NOW(a_back_in_window, state_ff == ST_BK_RUN, s_ff > lo_ff,
                   "backward scan left window")
   `PWF_ASSERT_NOW(a_fwd_in_window, state_ff == ST_FW_RUN,
                   ({1'b0, e_ff} + COUNT_W'(1)) < hi_ff, "forward scan left window")
   `PWF_ASSERT_NEXT(a_last_starts_scan, req_xfer && req_tlast, state_ff == ST_SETUP,
                    "final sample did not start scan")

endmodule

// ===== tb/sv/pulse_window_checker.sv =====
// Checker for the pulse window finder: predicts each pulse window and compares the results.
module pulse_window_checker
   import pwf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [13:0] raw_sample
   input  logic                  req_tlast,   // last_sample
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [11:0] peak_index, [26:12] peak_height,
                                              // [38:27] start_index, [50:39] end_index
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    open_results
);

   localparam int REPORT_LIMIT = 10;

   // One pulse window, highest field first so it matches the rsp_tdata layout
   typedef struct packed {
      logic [ADDR_W-1:0]         end_idx;
      logic [ADDR_W-1:0]         start_idx;
      logic signed [VALUE_W-1:0] height;
      logic [ADDR_W-1:0]         peak_idx;
   } window_type;

   localparam int WINDOW_W = $bits(window_type);

   // Shadow configuration
   logic [SAMPLE_W-1:0] pedestal;
   logic [1:0]          rule_back;
   logic [1:0]          rule_fwd;
   logic [FRAC_W-1:0]   fraction;
   logic [ADDR_W-1:0]   reach;

   // Shadow waveform
   logic signed [VALUE_W-1:0] wave_mem [MAX_SAMPLES];
   int held;
   int top_value;
   int top_pos;

   window_type pending_windows [$];

   // True while a scan may step past the sample 'here'; 'beyond' is its outer neighbour
   function automatic logic keeps_going(input logic [1:0] rule, input int here,
                                        input int beyond, input int peak);
      case (rule)
         RULE_SLOPE:    return here > beyond;
         RULE_PEDESTAL: return here > 0;
         RULE_FRACTION: return here * 256 > peak * int'(fraction);
         default:       return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin
      window_type got;
      window_type want;
      int      value;
      int      span;
      int      lo;
      int      hi;
      int      s;
      int      e;
      if (reset) begin
         pedestal       = '0;
         rule_back      = RULE_FRACTION;
         rule_fwd       = RULE_FRACTION;
         fraction       = 8'd26;
         reach          = 12'd100;
         held           = 0;
         top_value      = -(1 << SAMPLE_W);
         top_pos        = 0;
         mismatch_count = 0;
         pending_windows.delete();
         open_results  <= 0;
      end else begin
         // Compare a result transfer with the oldest predicted window
         if (rsp_tvalid && rsp_tready) begin
            got = window_type'(rsp_tdata[WINDOW_W-1:0]);
            if (pending_windows.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected result: peak %0d height %0d start %0d end %0d",
                           got.peak_idx, got.height, got.start_idx, got.end_idx);
            end else begin
               want = pending_windows.pop_front();
               if (got.peak_idx != want.peak_idx || got.height != want.height ||
                   got.start_idx != want.start_idx || got.end_idx != want.end_idx ||
                   rsp_tdata[RSP_DATA_W-1:WINDOW_W] != '0) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"window mismatch: expected peak %0d height %0d start %0d ",
                               "end %0d, got peak %0d height %0d start %0d end %0d pad %0h"},
                              want.peak_idx, want.height, want.start_idx, want.end_idx,
                              got.peak_idx, got.height, got.start_idx, got.end_idx,
                              rsp_tdata[RSP_DATA_W-1:WINDOW_W]);
               end
            end
         end

         // Store a sample transfer and close the waveform on its last sample
         if (req_tvalid && req_tready) begin
            if (held < MAX_SAMPLES) begin
               value = int'(pedestal) - int'(req_tdata[SAMPLE_W-1:0]);
               wave_mem[held] = VALUE_W'(value);
               if (value > top_value) begin
                  top_value = value;
                  top_pos   = held;
               end
               held++;
            end
            if (req_tlast) begin
               span = (reach == '0) ? 1 : int'(reach);
               lo   = (top_pos > span) ? top_pos - span : 0;
               hi   = (top_pos + span < held) ? top_pos + span : held;
               // Walk down from the peak
               if (top_pos <= lo) begin
                  s = top_pos;
               end else begin
                  s = top_pos - 1;
                  while (s > lo && keeps_going(rule_back, wave_mem[s], wave_mem[s-1],
                                               top_value))
                     s--;
               end
               // Walk up from the peak
               if (top_pos + 1 >= hi) begin
                  e = top_pos;
               end else begin
                  e = top_pos + 1;
                  while (e + 1 < hi && keeps_going(rule_fwd, wave_mem[e], wave_mem[e+1],
                                                   top_value))
                     e++;
               end
               want.peak_idx  = ADDR_W'(top_pos);
               want.height    = VALUE_W'(top_value);
               want.start_idx = ADDR_W'(s);
               want.end_idx   = ADDR_W'(e);
               pending_windows = {pending_windows, want};
               held      = 0;
               top_value = -(1 << SAMPLE_W);
               top_pos   = 0;
            end
         end

         // Apply a register transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PEDESTAL:    pedestal  = csr_wdata[SAMPLE_W-1:0];
               CSR_START_RULE:  rule_back = csr_wdata[1:0];
               CSR_END_RULE:    rule_fwd  = csr_wdata[1:0];
               CSR_FRACTION_Q8: fraction  = csr_wdata[FRAC_W-1:0];
               CSR_SCAN_REACH:  reach     = csr_wdata[ADDR_W-1:0];
               default: ;
            endcase
         end

         open_results <= pending_windows.size();
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the pulse window finder testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
   import pwf_pkg::*;

   localparam logic [1:0]           RULE_NEVER   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE    = 3'd7;
   localparam int                   QUIET_LIMIT  = 50000;
   localparam int                   HOLD_CYCLES  = 600;
   localparam int                   SEGMENTS     = 12;
   localparam int                   RANDOM_ITEMS = 1330;
   localparam int                   SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int mismatch_count;
   int open_results;
   int tx_idle_pct   = 15;
   int rx_idle_pct   = 56;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int items_sent    = 0;

   logic [SAMPLE_W-1:0] ped_now   = '0;
   logic [ADDR_W-1:0]   reach_now = 12'd100;

   pulse_window_finder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pulse_window_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .open_results   (open_results)
   );

   always #5 clock = ~clock;

   // Receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_tready   <= 1'b0;
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Watchdog: end the run after too long without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("pulse_window_finder_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one sample after a random gap and hold it until it transfers
   task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(raw);
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Hold one register write until it transfers; csr_valid is lowered by the caller
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write every register, with junk above each field
   task automatic configure(input logic [SAMPLE_W-1:0] ped, input logic [1:0] back_rule,
                            input logic [1:0] fwd_rule, input logic [FRAC_W-1:0] frac,
                            input logic [ADDR_W-1:0] reach);
      write_reg(CSR_SPARE, 16'($urandom()));
      write_reg(CSR_PEDESTAL, {2'($urandom()), ped});
      write_reg(CSR_START_RULE, {14'($urandom()), back_rule});
      write_reg(CSR_END_RULE, {14'($urandom()), fwd_rule});
      write_reg(CSR_FRACTION_Q8, {8'($urandom()), frac});
      write_reg(CSR_SCAN_REACH, {4'($urandom()), reach});
      csr_valid <= 1'b0;
      ped_now   = ped;
      reach_now = reach;
   endtask

   // Stop offering, wait for every window, then for the longest scan
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
      repeat (2 * ((reach_now == '0) ? 1 : int'(reach_now)) + 16) @(posedge clock);
   endtask

   task automatic random_config();
      logic [SAMPLE_W-1:0] ped;
      logic [1:0]          back_rule;
      logic [1:0]          fwd_rule;
      logic [FRAC_W-1:0]   frac;
      logic [ADDR_W-1:0]   reach;
      case ($urandom_range(3))
         0:       ped = '0;
         1:       ped = SAMPLE_W'(SAMPLE_MAX);
         default: ped = SAMPLE_W'($urandom_range(SAMPLE_MAX));
      endcase
      back_rule = ($urandom_range(7) == 0) ? RULE_NEVER : 2'($urandom_range(2));
      fwd_rule  = ($urandom_range(7) == 0) ? RULE_NEVER : 2'($urandom_range(2));
      case ($urandom_range(3))
         0:       frac = '0;
         1:       frac = 8'd255;
         default: frac = 8'($urandom_range(255));
      endcase
      case ($urandom_range(5))
         0:       reach = '0;
         1:       reach = 12'd4095;
         2:       reach = 12'd1;
         default: reach = 12'($urandom_range(2, 30));
      endcase
      configure(ped, back_rule, fwd_rule, frac, reach);
   endtask

   // One waveform: noise, flat line or a dip below the baseline
   task automatic send_waveform(input int len);
      int style;
      int centre;
      int half;
      int depth;
      int offset;
      int noise;
      int gap;
      int level;
      int raw;
      style  = $urandom_range(9);
      centre = $urandom_range(len - 1);
      half   = $urandom_range(1, 12);
      depth  = $urandom_range(SAMPLE_MAX);
      offset = int'($urandom_range(40)) - 20;
      noise  = (style >= 6) ? 0 : 3;
      for (int i = 0; i < len; i++) begin
         if (style == 0) begin
            raw = $urandom_range(SAMPLE_MAX);
         end else if (style == 1) begin
            raw = ped_now;
         end else begin
            gap   = (i > centre) ? i - centre : centre - i;
            level = (gap >= half) ? 0 : depth * (half - gap) / half;
            raw   = int'(ped_now) + offset - level + int'($urandom_range(2 * noise)) - noise;
         end
         if (raw < 0) raw = 0;
         if (raw > SAMPLE_MAX) raw = SAMPLE_MAX;
         send_sample(SAMPLE_W'(raw), i == len - 1);
      end
   endtask

   initial begin
      int series [$];
      int budget;
      int len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-sample waveforms at both extremes of the raw value
      send_sample('0, 1'b1);
      send_sample(SAMPLE_W'(SAMPLE_MAX), 1'b1);
      drain();

      // Zero reach, rules that never hold, equal maxima
      configure(SAMPLE_W'(SAMPLE_MAX), RULE_NEVER, RULE_NEVER, 8'd26, '0);
      series = '{SAMPLE_MAX, 100, 0, 0, 50};
      foreach (series[i]) send_sample(SAMPLE_W'(series[i]), i == series.size() - 1);
      drain();

      // Slope rule both ways, widest reach, full fraction
      configure(14'd8000, RULE_SLOPE, RULE_SLOPE, 8'd255, 12'd4095);
      series = '{8000, 7990, 7000, 5000, 7500, 7600, 7700, 7650, 7990};
      foreach (series[i]) send_sample(SAMPLE_W'(series[i]), i == series.size() - 1);
      drain();

      // Pedestal crossing backward, zero fraction forward
      configure(14'd500, RULE_PEDESTAL, RULE_FRACTION, '0, 12'd2);
      series = '{600, 450, 300, 100, 200, 499, 700, 400};
      foreach (series[i]) send_sample(SAMPLE_W'(series[i]), i == series.size() - 1);
      drain();

      // Random waveforms over several settings and idling phases
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == SEGMENTS / 3) begin
            tx_idle_pct = 56;
            rx_idle_pct = 15;
         end
         if (seg == 2 * SEGMENTS / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         random_config();
         if (seg == SEGMENTS - 3)
            hold_requests <= hold_requests + 1;
         budget = items_sent + RANDOM_ITEMS / SEGMENTS;
         while (items_sent < budget) begin
            case ($urandom_range(19))
               0:       len = 1;
               1:       len = $urandom_range(60, 300);
               default: len = $urandom_range(2, 24);
            endcase
            // Trim the last waveform of the segment to the item budget
            if (len > budget - items_sent)
               len = budget - items_sent;
            send_waveform(len);
         end
         drain();
      end

      if (mismatch_count == 0 && open_results == 0)
         $display("pulse_window_finder_core test passed");
      else
         $display("pulse_window_finder_core test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pwf_pkg.sv
rtl/pulse_window_finder_core.sv
tb/sv/pulse_window_checker.sv
tb/sv/testbench.sv
